/* rtl/qrs_pkg.sv */
`default_nettype none
package qrs_pkg;

  localparam int unsigned COEF_WIDTH_DEF = 32;
  localparam int unsigned PORT_W = 32;
  localparam int unsigned FRAC_W = 16;
  localparam int unsigned SQ_BITS = 34;
  localparam int unsigned SQ_W = 68;
  localparam int unsigned DISC_W = 66;
  localparam int unsigned NUM_W = 51;
  localparam int unsigned DEN_W = 33;
  localparam int unsigned Q_W = 33;
  localparam int unsigned DIV_CW = 66;
  localparam int unsigned LANES = 2;

  localparam logic [31:0] EPS_RESET = 32'd4;
  localparam logic [31:0] ROOT_NONE = 32'hFFFF0000;
  localparam logic [31:0] POS_MAX = 32'h7FFFFFFF;
  localparam logic [31:0] NEG_MAX = 32'h80000000;

  localparam logic [1:0] CNT_NONE = 2'd0;
  localparam logic [1:0] CNT_ONE = 2'd1;
  localparam logic [1:0] CNT_TWO = 2'd2;
  localparam logic [1:0] CNT_INF = 2'd3;

  typedef enum logic [2:0] {
    KIND_NONE = 3'd0,
    KIND_INF  = 3'd1,
    KIND_LIN  = 3'd2,
    KIND_DBL  = 3'd3,
    KIND_TWO  = 3'd4
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [31:0] am;
    logic        an;
    logic [31:0] bm;
    logic        bn;
    logic [31:0] cm;
    logic        cn;
  } side_t;

  typedef struct packed {
    side_t               side;
    logic [SQ_W-1:0]     rem;
    logic [SQ_BITS-1:0]  root;
  } sq_t;

  typedef struct packed {
    logic             neg;
    logic             ovf;
    logic [NUM_W-1:0] rem;
    logic [Q_W-1:0]   quo;
  } lane_t;

  typedef struct packed {
    kind_e                 kind;
    logic [DEN_W-1:0]      den;
    lane_t [LANES-1:0]     lane;
  } dv_t;

endpackage
`default_nettype wire

/* rtl/qrs_sqrt_cell.sv */
`default_nettype none
module qrs_sqrt_cell import qrs_pkg::*; #(
  parameter int unsigned BIT = 0
) (
  input  wire       clk_i,
  input  wire       rst_ni,
  input  wire       valid_i,
  output logic      ready_o,
  input  wire sq_t  data_i,
  output logic      valid_o,
  input  wire       ready_i,
  output sq_t       data_o
);

  logic [SQ_W-1:0] trial;
  logic            take;
  sq_t             data_d;
  logic            valid_q;
  sq_t             data_q;

  // root bits below this one are still zero, so the or is an add
  assign trial = (SQ_W'(data_i.root) << (BIT + 1)) | (SQ_W'(1) << (2 * BIT));
  assign take  = trial <= data_i.rem;

  always_comb begin
    data_d = data_i;
    if (take) begin
      data_d.rem  = data_i.rem - trial;
      data_d.root = data_i.root | (SQ_BITS'(1) << BIT);
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule
`default_nettype wire

/* rtl/qrs_div_cell.sv */
`default_nettype none
module qrs_div_cell import qrs_pkg::*; #(
  parameter int unsigned BIT = 0
) (
  input  wire       clk_i,
  input  wire       rst_ni,
  input  wire       valid_i,
  output logic      ready_o,
  input  wire dv_t  data_i,
  output logic      valid_o,
  input  wire       ready_i,
  output dv_t       data_o
);

  logic [DIV_CW-1:0] dsh;
  dv_t               data_d;
  logic              valid_q;
  dv_t               data_q;

  assign dsh = DIV_CW'(data_i.den) << BIT;

  always_comb begin
    data_d = data_i;
    for (int l = 0; l < LANES; l++) begin
      if (data_i.den != '0 && DIV_CW'(data_i.lane[l].rem) >= dsh) begin
        data_d.lane[l].rem = data_i.lane[l].rem - dsh[NUM_W-1:0];
        data_d.lane[l].quo = data_i.lane[l].quo | (Q_W'(1) << BIT);
      end
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule
`default_nettype wire

/* rtl/quadratic_root_solver.sv */
// quadratic root solver: one equation a*x^2 + b*x + c = 0 per item
// input channel in_valid_i/in_ready_o carries coef_a_i, coef_b_i, coef_c_i
// (signed Q16.16, low COEF_WIDTH bits used, sign extended from the top one)
// output channel out_valid_o/out_ready_i carries root_count_o, root_one_o,
// root_two_o and saturated_o, one result item per input item, in order
// cfg_we_i writes cfg_wdata_i into the epsilon band register at once
// the result passes through three front stages (magnitudes, products,
// discriminant), 34 square root cells, one operand stage, 33 divider cells
// and the output register
// throughput is one item per cycle while the receiver takes results; every
// stage is a cell that hands its work to the next one when that one can
// take it, the square root and the quotients taking one bit per cell
// when the receiver stalls, each stage holds only while the next is full,
// so bubbles close up and items keep being accepted until the chain fills
// reset empties every stage and sets epsilon to 4
`default_nettype none
module quadratic_root_solver import qrs_pkg::*; #(
  parameter int unsigned COEF_WIDTH = COEF_WIDTH_DEF
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                cfg_we_i,
  input  wire  [31:0]        cfg_wdata_i,
  input  wire                in_valid_i,
  output logic               in_ready_o,
  input  wire  [PORT_W-1:0]  coef_a_i,
  input  wire  [PORT_W-1:0]  coef_b_i,
  input  wire  [PORT_W-1:0]  coef_c_i,
  output logic               out_valid_o,
  input  wire                out_ready_i,
  output logic [1:0]         root_count_o,
  output logic [PORT_W-1:0]  root_one_o,
  output logic [PORT_W-1:0]  root_two_o,
  output logic               saturated_o
);

  localparam int unsigned UW = (COEF_WIDTH < PORT_W) ? COEF_WIDTH : PORT_W;

  function automatic logic [32:0] coef_mag(input logic [PORT_W-1:0] v);
    logic [UW-1:0] lo;
    logic          neg;
    lo  = v[UW-1:0];
    neg = lo[UW-1];
    coef_mag = {neg, neg ? 32'(UW'(~lo + 1'b1)) : 32'(lo)};
  endfunction

  function automatic logic [32:0] make_root(input lane_t ln);
    logic [32:0] res;
    if (ln.neg) begin
      if (ln.ovf || ln.quo > Q_W'(NEG_MAX)) begin
        res = {1'b1, NEG_MAX};
      end else begin
        res = {1'b0, 32'(~ln.quo + 1'b1)};
      end
    end else begin
      if (ln.ovf || ln.quo > Q_W'(POS_MAX)) begin
        res = {1'b1, POS_MAX};
      end else begin
        res = {1'b0, ln.quo[31:0]};
      end
    end
    make_root = res;
  endfunction

  logic [31:0] eps_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eps_q <= EPS_RESET;
    end else if (cfg_we_i) begin
      eps_q <= cfg_wdata_i;
    end
  end

  // stage 1: magnitudes and signs
  logic        s1_v_q, s1_rdy, s2_rdy;
  logic [32:0] ma, mb, mc;
  side_t       s1_q;

  assign ma = coef_mag(coef_a_i);
  assign mb = coef_mag(coef_b_i);
  assign mc = coef_mag(coef_c_i);
  assign s1_rdy = !s1_v_q || s2_rdy;
  assign in_ready_o = s1_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (s1_rdy) begin
      s1_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_rdy && in_valid_i) begin
      s1_q <= '{kind: KIND_NONE, am: ma[31:0], an: ma[32], bm: mb[31:0], bn: mb[32],
                cm: mc[31:0], cn: mc[32]};
    end
  end

  // stage 2: products
  logic        s2_v_q, s3_rdy;
  side_t       s2_q;
  logic [63:0] b2_q, ac_q;

  assign s2_rdy = !s2_v_q || s3_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else if (s2_rdy) begin
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_rdy && s1_v_q) begin
      s2_q <= s1_q;
      b2_q <= 64'(s1_q.bm) * 64'(s1_q.bm);
      ac_q <= 64'(s1_q.am) * 64'(s1_q.cm);
    end
  end

  // stage 3: discriminant and case
  logic               s3_v_q;
  logic [65:0]        fl;
  logic signed [66:0] disc;
  logic [DISC_W-1:0]  dmag;
  kind_e              kind;
  side_t              s3_side;
  sq_t                s3_q;

  logic               sq_v [SQ_BITS+1];
  logic               sq_r [SQ_BITS+1];
  sq_t                sq_d [SQ_BITS+1];

  assign fl   = {ac_q, 2'b00};
  assign disc = (s2_q.an == s2_q.cn) ? $signed({3'b000, b2_q}) - $signed({1'b0, fl})
                                     : $signed({3'b000, b2_q}) + $signed({1'b0, fl});
  assign dmag = disc[66] ? DISC_W'(-disc) : disc[DISC_W-1:0];

  always_comb begin
    if (s2_q.am == '0 && s2_q.bm == '0) begin
      kind = (s2_q.cm == '0) ? KIND_INF : KIND_NONE;
    end else if (s2_q.am == '0) begin
      kind = KIND_LIN;
    end else if (dmag <= DISC_W'(eps_q)) begin
      kind = KIND_DBL;
    end else if (disc[66]) begin
      kind = KIND_NONE;
    end else begin
      kind = KIND_TWO;
    end
  end

  always_comb begin
    s3_side      = s2_q;
    s3_side.kind = kind;
  end

  assign s3_rdy = !s3_v_q || sq_r[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_v_q <= 1'b0;
    end else if (s3_rdy) begin
      s3_v_q <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s3_rdy && s2_v_q) begin
      s3_q <= '{side: s3_side, rem: (kind == KIND_TWO) ? SQ_W'(dmag) : SQ_W'(0),
                root: SQ_BITS'(0)};
    end
  end

  assign sq_v[0] = s3_v_q;
  assign sq_d[0] = s3_q;

  for (genvar i = 0; i < SQ_BITS; i++) begin : g_sqrt
    qrs_sqrt_cell #(
      .BIT(SQ_BITS - 1 - i)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .valid_i(sq_v[i]),
      .ready_o(sq_r[i]),
      .data_i (sq_d[i]),
      .valid_o(sq_v[i+1]),
      .ready_i(sq_r[i+1]),
      .data_o (sq_d[i+1])
    );
  end

  // operand stage for the two divider lanes
  logic               pp_v_q;
  side_t              sd;
  logic signed [35:0] nb, sx, n1, n2;
  logic [34:0]        m1, m2;
  dv_t                pp_d, pp_q;

  logic               dv_v [Q_W+1];
  logic               dv_r [Q_W+1];
  dv_t                dv_d [Q_W+1];

  assign sd = sq_d[SQ_BITS].side;
  assign nb = sd.bn ? $signed({4'b0000, sd.bm}) : -$signed({4'b0000, sd.bm});
  assign sx = $signed({2'b00, sq_d[SQ_BITS].root});
  assign n1 = nb + sx;
  assign n2 = nb - sx;
  assign m1 = n1[35] ? 35'(-n1) : n1[34:0];
  assign m2 = n2[35] ? 35'(-n2) : n2[34:0];

  always_comb begin
    pp_d      = '0;
    pp_d.kind = sd.kind;
    unique case (sd.kind)
      KIND_LIN: begin
        pp_d.den          = DEN_W'(sd.bm);
        pp_d.lane[0].neg  = sd.cn == sd.bn;
        pp_d.lane[0].rem  = (sd.cm == '0) ? '0 : {3'b000, sd.cm, 16'h0000};
      end
      KIND_DBL: begin
        pp_d.den          = {sd.am, 1'b0};
        pp_d.lane[0].neg  = (sd.bn == sd.an) && (sd.bm != '0);
        pp_d.lane[0].rem  = {3'b000, sd.bm, 16'h0000};
      end
      KIND_TWO: begin
        pp_d.den          = {sd.am, 1'b0};
        pp_d.lane[0].neg  = (n1[35] != sd.an) && (m1 != '0);
        pp_d.lane[0].rem  = {m1, 16'h0000};
        pp_d.lane[1].neg  = (n2[35] != sd.an) && (m2 != '0);
        pp_d.lane[1].rem  = {m2, 16'h0000};
      end
      default: begin
        pp_d.den = '0;
      end
    endcase
    for (int l = 0; l < LANES; l++) begin
      if (pp_d.den != '0 && DEN_W'(pp_d.lane[l].rem[NUM_W-1:Q_W]) >= pp_d.den) begin
        pp_d.lane[l].ovf = 1'b1;
        pp_d.lane[l].rem = '0;
      end
    end
  end

  assign sq_r[SQ_BITS] = !pp_v_q || dv_r[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pp_v_q <= 1'b0;
    end else if (sq_r[SQ_BITS]) begin
      pp_v_q <= sq_v[SQ_BITS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (sq_r[SQ_BITS] && sq_v[SQ_BITS]) begin
      pp_q <= pp_d;
    end
  end

  assign dv_v[0] = pp_v_q;
  assign dv_d[0] = pp_q;

  for (genvar i = 0; i < Q_W; i++) begin : g_div
    qrs_div_cell #(
      .BIT(Q_W - 1 - i)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .valid_i(dv_v[i]),
      .ready_o(dv_r[i]),
      .data_i (dv_d[i]),
      .valid_o(dv_v[i+1]),
      .ready_i(dv_r[i+1]),
      .data_o (dv_d[i+1])
    );
  end

  // output register
  logic        out_v_q;
  logic [32:0] rt0, rt1;
  logic [1:0]  cnt;
  logic [1:0]  cnt_q;
  logic [31:0] r1_q, r2_q;
  logic        sat_q;

  assign rt0 = make_root(dv_d[Q_W].lane[0]);
  assign rt1 = make_root(dv_d[Q_W].lane[1]);

  always_comb begin
    unique case (dv_d[Q_W].kind)
      KIND_INF: cnt = CNT_INF;
      KIND_LIN: cnt = CNT_ONE;
      KIND_DBL: cnt = CNT_ONE;
      KIND_TWO: cnt = CNT_TWO;
      default:  cnt = CNT_NONE;
    endcase
  end

  assign dv_r[Q_W] = !out_v_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (dv_r[Q_W]) begin
      out_v_q <= dv_v[Q_W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (dv_r[Q_W] && dv_v[Q_W]) begin
      cnt_q <= cnt;
      r1_q  <= (cnt == CNT_NONE) ? ROOT_NONE : rt0[31:0];
      r2_q  <= rt1[31:0];
      sat_q <= rt0[32] | rt1[32];
    end
  end

  assign out_valid_o  = out_v_q;
  assign root_count_o = cnt_q;
  assign root_one_o   = r1_q;
  assign root_two_o   = r2_q;
  assign saturated_o  = sat_q;

endmodule
`default_nettype wire

/* sim/tb_top.sv */
module tb_top;
  import qrs_pkg::*;

  typedef struct packed {
    logic [1:0]  count;
    logic [31:0] r1;
    logic [31:0] r2;
    logic        sat;
  } roots_t;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic        typed;
    roots_t      want;
  } row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we = 1'b0;
  logic [31:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] coef_a = '0, coef_b = '0, coef_c = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  root_count;
  logic [31:0] root_one, root_two;
  logic        saturated;

  logic [31:0] eps_shadow = EPS_RESET;
  int          send_idle = 0;
  int          recv_stall = 0;
  int          errors = 0;
  roots_t      expected_roots[$];
  row_t        rows[$];

  quadratic_root_solver i_dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_we_i(cfg_we), .cfg_wdata_i(cfg_wdata),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .coef_a_i(coef_a), .coef_b_i(coef_b), .coef_c_i(coef_c),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .root_count_o(root_count), .root_one_o(root_one),
    .root_two_o(root_two), .saturated_o(saturated)
  );

  always #10 clk_i = ~clk_i;

  function automatic logic [31:0] clip_quot(input logic neg, input logic [63:0] num,
                                            input logic [63:0] den, inout logic sat);
    logic [63:0] q;
    q = (den == 0) ? 64'd0 : num / den;
    if (neg) begin
      if (q > 64'h80000000) begin
        sat = 1'b1;
        return NEG_MAX;
      end
      return 32'(~q + 64'd1);
    end
    if (q > 64'h7FFFFFFF) begin
      sat = 1'b1;
      return POS_MAX;
    end
    return q[31:0];
  endfunction

  function automatic roots_t solve_quadratic(input logic [31:0] a, input logic [31:0] b,
                                             input logic [31:0] c, input logic [31:0] eps);
    roots_t             r;
    logic               an, bn, cn, dneg, s1, s2;
    logic [63:0]        am, bm, cm, m1, m2;
    logic [65:0]        b2, f4, dmag;
    logic [67:0]        cand;
    logic [33:0]        sq;
    logic signed [67:0] nb, n1, n2;
    an = a[31]; bn = b[31]; cn = c[31];
    am = {32'd0, an ? -a : a};
    bm = {32'd0, bn ? -b : b};
    cm = {32'd0, cn ? -c : c};
    r = '0;
    if (am == 0 && bm == 0) begin
      r.count = (cm == 0) ? CNT_INF : CNT_NONE;
      if (cm != 0) r.r1 = ROOT_NONE;
    end else if (am == 0) begin
      r.count = CNT_ONE;
      if (cm != 0) r.r1 = clip_quot(cn == bn, cm << 16, bm, r.sat);
    end else begin
      b2 = 66'(bm) * 66'(bm);
      f4 = (66'(am) * 66'(cm)) << 2;
      dneg = 1'b0;
      if (f4 != 0 && an == cn) begin
        if (f4 > b2) begin
          dneg = 1'b1;
          dmag = f4 - b2;
        end else begin
          dmag = b2 - f4;
        end
      end else begin
        dmag = b2 + f4;
      end
      if (dmag <= 66'(eps)) begin
        r.count = CNT_ONE;
        r.r1 = clip_quot(bn == an && bm != 0, bm << 16, am << 1, r.sat);
      end else if (dneg) begin
        r.count = CNT_NONE;
        r.r1 = ROOT_NONE;
      end else begin
        sq = '0;
        for (int i = 33; i >= 0; i--) begin
          cand = 68'(sq | (34'd1 << i));
          if (cand * cand <= 68'(dmag)) sq = cand[33:0];
        end
        nb = bn ? $signed(68'(bm)) : -$signed(68'(bm));
        n1 = nb + $signed(68'(sq));
        n2 = nb - $signed(68'(sq));
        s1 = n1 < 0;
        s2 = n2 < 0;
        m1 = 64'(s1 ? -n1 : n1);
        m2 = 64'(s2 ? -n2 : n2);
        r.count = CNT_TWO;
        r.r1 = clip_quot((s1 != an) && m1 != 0, m1 << 16, am << 1, r.sat);
        r.r2 = clip_quot((s2 != an) && m2 != 0, m2 << 16, am << 1, r.sat);
      end
    end
    return r;
  endfunction

  task automatic offer_coefs(input logic [31:0] a, input logic [31:0] b,
                             input logic [31:0] c, input logic typed, input roots_t want);
    while ($urandom_range(0, 99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    in_valid <= 1'b1;
    coef_a <= a;
    coef_b <= b;
    coef_c <= c;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    expected_roots.push_back(typed ? want : solve_quadratic(a, b, c, eps_shadow));
    @(negedge clk_i);
  endtask

  task automatic random_coefs();
    logic [31:0] a, b, c;
    int          p, q, k;
    case ($urandom_range(0, 9))
      0, 1: begin
        a = $urandom; b = $urandom; c = $urandom;
      end
      2, 3: begin
        a = 32'($signed(20'($urandom)));
        b = 32'($signed(22'($urandom)));
        c = 32'($signed(20'($urandom)));
      end
      4: begin
        a = ($urandom_range(0, 3) == 0) ? 32'd0 : $urandom;
        b = ($urandom_range(0, 3) == 0) ? 32'd0 : $urandom;
        c = ($urandom_range(0, 3) == 0) ? 32'd0 : $urandom;
        if ($urandom_range(0, 1)) a = 32'd0;
      end
      default: begin
        p = $urandom_range(0, 16) - 8;
        q = ($urandom_range(0, 3) == 0) ? p : $urandom_range(0, 16) - 8;
        k = $urandom_range(1, 4) * (($urandom_range(0, 1) == 1) ? 1 : -1);
        a = 32'(k) << 16;
        b = 32'(-k * (p + q)) << 16;
        c = 32'(k * p * q) << 16;
        if ($urandom_range(0, 4) == 0) c = c + 32'($urandom_range(0, 7)) - 32'd3;
      end
    endcase
    offer_coefs(a, b, c, 1'b0, '0);
  endtask

  task automatic set_phase(input int idle, input int stall, input logic wr,
                           input logic [31:0] eps);
    in_valid <= 1'b0;
    while (expected_roots.size() != 0) @(negedge clk_i);
    repeat (80) @(negedge clk_i);
    send_idle = idle;
    recv_stall = stall;
    if (wr) begin
      cfg_we <= 1'b1;
      cfg_wdata <= eps;
      @(negedge clk_i);
      cfg_we <= 1'b0;
      eps_shadow = eps;
    end
  endtask

  function automatic row_t mk(input logic [31:0] a, input logic [31:0] b, input logic [31:0] c,
                              input logic typed, input logic [1:0] n, input logic [31:0] r1,
                              input logic [31:0] r2, input logic sat);
    row_t t;
    t.a = a; t.b = b; t.c = c; t.typed = typed;
    t.want = '{n, r1, r2, sat};
    return t;
  endfunction

  always @(negedge clk_i) begin
    if (rst_ni) out_ready <= ($urandom_range(0, 99) >= recv_stall);
  end

  always @(posedge clk_i) begin
    roots_t got, exp_r;
    if (rst_ni && out_valid && out_ready) begin
      got = '{root_count, root_one, root_two, saturated};
      if (expected_roots.size() == 0) begin
        $display("%0t unexpected item: actual %h", $time, got);
        errors++;
      end else begin
        exp_r = expected_roots.pop_front();
        if (got.count !== exp_r.count) begin
          $display("%0t root_count: expected %h actual %h", $time, exp_r.count, got.count);
          errors++;
        end
        if (got.r1 !== exp_r.r1) begin
          $display("%0t root_one: expected %h actual %h", $time, exp_r.r1, got.r1);
          errors++;
        end
        if (got.r2 !== exp_r.r2) begin
          $display("%0t root_two: expected %h actual %h", $time, exp_r.r2, got.r2);
          errors++;
        end
        if (got.sat !== exp_r.sat) begin
          $display("%0t saturated: expected %h actual %h", $time, exp_r.sat, got.sat);
          errors++;
        end
      end
    end
  end

  initial begin
    #8000000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    rows.push_back(mk(0, 0, 0, 1, CNT_INF, 0, 0, 0));
    rows.push_back(mk(0, 0, 32'd1, 1, CNT_NONE, ROOT_NONE, 0, 0));
    rows.push_back(mk(0, 0, NEG_MAX, 1, CNT_NONE, ROOT_NONE, 0, 0));
    rows.push_back(mk(0, 32'h00010000, 0, 1, CNT_ONE, 0, 0, 0));
    rows.push_back(mk(0, 32'h00010000, 32'h00010000, 1, CNT_ONE, ROOT_NONE, 0, 0));
    rows.push_back(mk(0, 32'd1, POS_MAX, 1, CNT_ONE, NEG_MAX, 0, 1));
    rows.push_back(mk(0, 32'hFFFFFFFF, POS_MAX, 1, CNT_ONE, POS_MAX, 0, 1));
    rows.push_back(mk(32'h00010000, 0, 32'h00010000, 1, CNT_NONE, ROOT_NONE, 0, 0));
    rows.push_back(mk(32'h00010000, 0, 32'hFFFF0000, 1, CNT_TWO, 32'h00010000,
                      ROOT_NONE, 0));
    rows.push_back(mk(32'h00010000, 32'hFFFE0000, 32'h00010000, 1, CNT_ONE,
                      32'h00010000, 0, 0));
    rows.push_back(mk(NEG_MAX, NEG_MAX, NEG_MAX, 0, 0, 0, 0, 0));
    rows.push_back(mk(POS_MAX, POS_MAX, POS_MAX, 0, 0, 0, 0, 0));
    rows.push_back(mk(POS_MAX, NEG_MAX, NEG_MAX, 0, 0, 0, 0, 0));
    rows.push_back(mk(NEG_MAX, POS_MAX, POS_MAX, 0, 0, 0, 0, 0));
    rows.push_back(mk(32'd1, POS_MAX, 0, 0, 0, 0, 0, 0));
    rows.push_back(mk(32'd1, NEG_MAX, 32'd1, 0, 0, 0, 0, 0));
    rows.push_back(mk(32'hFFFFFFFF, 0, 32'd1, 0, 0, 0, 0, 0));
    rows.push_back(mk(32'd1, 32'd4, 32'd4, 0, 0, 0, 0, 0));
    rows.push_back(mk(32'd1, 32'd4, 32'd5, 0, 0, 0, 0, 0));
    rows.push_back(mk(32'd1, 32'd4, 32'd3, 0, 0, 0, 0, 0));
    rows.push_back(mk(32'd1, 32'd1, 0, 0, 0, 0, 0, 0));
    rows.push_back(mk(32'h00020000, 32'h00010000, 32'hFFFD0000, 0, 0, 0, 0, 0));

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    foreach (rows[i]) offer_coefs(rows[i].a, rows[i].b, rows[i].c, rows[i].typed,
                                  rows[i].want);
    repeat (100) random_coefs();
    set_phase(72, 0, 1'b1, 32'd0);
    repeat (100) random_coefs();
    set_phase(0, 72, 1'b1, 32'hFFFFFFFF);
    repeat (100) random_coefs();
    set_phase(12, 12, 1'b1, $urandom);
    repeat (100) random_coefs();
    set_phase(0, 0, 1'b1, 32'd1000);
    repeat (100) random_coefs();
    set_phase(72, 72, 1'b1, EPS_RESET);
    repeat (100) random_coefs();
    set_phase(12, 12, 1'b1, 32'd1);
    repeat (100) random_coefs();
    in_valid <= 1'b0;
    while (expected_roots.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
